### rtl/hbrd_pkg.sv
package hbrd_pkg;

    typedef enum logic [3:0] {
        TGT_NONE    = 4'd0,
        TGT_BIOS    = 4'd1,
        TGT_EWRAM   = 4'd2,
        TGT_IWRAM   = 4'd3,
        TGT_IO      = 4'd4,
        TGT_PALETTE = 4'd5,
        TGT_VRAM    = 4'd6,
        TGT_OAM     = 4'd7,
        TGT_ROM     = 4'd8,
        TGT_EEPROM  = 4'd9,
        TGT_BACKUP  = 4'd10
    } t_target;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_RSVD = 2'd3;

    localparam logic [1:0] BK_NONE   = 2'd0;
    localparam logic [1:0] BK_SRAM   = 2'd1;
    localparam logic [1:0] BK_FLASH  = 2'd2;
    localparam logic [1:0] BK_EEPROM = 2'd3;

    localparam logic [3:0] RGN_BIOS    = 4'h0;
    localparam logic [3:0] RGN_UNMAP   = 4'h1;
    localparam logic [3:0] RGN_EWRAM   = 4'h2;
    localparam logic [3:0] RGN_IWRAM   = 4'h3;
    localparam logic [3:0] RGN_IO      = 4'h4;
    localparam logic [3:0] RGN_PALETTE = 4'h5;
    localparam logic [3:0] RGN_VRAM    = 4'h6;
    localparam logic [3:0] RGN_OAM     = 4'h7;
    localparam logic [3:0] RGN_ROM_D   = 4'hD;
    localparam logic [3:0] RGN_SAVE_E  = 4'hE;
    localparam logic [3:0] RGN_SAVE_F  = 4'hF;

    // config register index, taken from paddr[2]
    localparam logic CFG_BACKUP_KIND = 1'b0;
    localparam logic CFG_BITMAP_MODE = 1'b1;

    localparam logic [16:0] VRAM_BG_END_BITMAP = 17'h13FFF;

    localparam logic [3:0] WAIT_NARROW [16] = '{
        4'd1, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd5, 4'd1
    };
    localparam logic [3:0] WAIT_WORD [16] = '{
        4'd1, 4'd1, 4'd6, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd1
    };

    typedef struct packed {
        logic        func;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        t_target     target;
        logic [24:0] offset;
        logic [3:0]  wait_cycles;
        logic        drop;
        logic [1:0]  store_width;
        logic [31:0] store_data;
        logic        fixed_read;
        logic [31:0] fixed_value;
        logic        replicate_byte;
    } t_rsp;

endpackage

### rtl/hbrd_if.sv
interface hbrd_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;

    modport source (output valid, func, access_size, address, write_data, input ready);
    modport sink   (input valid, func, access_size, address, write_data, output ready);
endinterface

interface hbrd_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  target;
    logic [24:0] offset;
    logic [3:0]  wait_cycles;
    logic        drop;
    logic [1:0]  store_width;
    logic [31:0] store_data;
    logic        fixed_read;
    logic [31:0] fixed_value;
    logic        replicate_byte;

    modport source (output valid, target, offset, wait_cycles, drop, store_width, store_data,
                    fixed_read, fixed_value, replicate_byte, input ready);
    modport sink   (input valid, target, offset, wait_cycles, drop, store_width, store_data,
                    fixed_read, fixed_value, replicate_byte, output ready);
endinterface

### rtl/handheld_bus_region_decoder.sv
// Bus region decoder for a handheld console memory map.
//
// Request channel (i_req): one bus access per beat - read/write, size, 32-bit
// address and write data. Response channel (o_rsp): one decode result per
// request - target region, masked offset, wait states, drop flag, the data and
// width actually stored, and any fixed read answer.
// Configuration: APB-style, backup_kind at 0x0 and bitmap_mode at 0x4; both
// are sampled with each request and should only change while idle.
//
// Pipeline: a request beat is held in an input register, decoded combinationally
// and lands in the response register. Throughput is one beat per cycle while
// o_rsp.ready is high, since each stage holds one access and both can move in
// the same cycle.
// Stall: when o_rsp.ready is low the response holds steady; the input stage
// keeps taking a beat as long as it is empty or can move into an empty
// response stage, and i_req.ready drops only once both stages are full.
// Reset (synchronous, active low) empties both stages and clears the two
// configuration registers to zero.
module handheld_bus_region_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hbrd_req_if.sink           i_req,
    hbrd_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic           r_in_valid;
    hbrd_pkg::t_req r_in;
    logic           r_out_valid;
    hbrd_pkg::t_rsp r_out;
    logic [1:0]     r_backup_kind;
    logic           r_bitmap_mode;

    hbrd_pkg::t_req n_in;
    hbrd_pkg::t_rsp n_out;
    logic           out_load;
    logic           in_load;
    logic           cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign out_load    = !r_out_valid || o_rsp.ready;
    assign in_load     = !r_in_valid || out_load;
    assign i_req.ready = in_load;

    always_comb begin
        n_in.func        = i_req.func;
        n_in.access_size = i_req.access_size;
        n_in.address     = i_req.address;
        n_in.write_data  = i_req.write_data;
    end

    always_comb begin
        case (paddr[2])
            hbrd_pkg::CFG_BACKUP_KIND: prdata = {30'h0, r_backup_kind};
            default:                   prdata = {31'h0, r_bitmap_mode};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backup_kind <= hbrd_pkg::BK_NONE;
            r_bitmap_mode <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                hbrd_pkg::CFG_BACKUP_KIND: r_backup_kind <= pwdata[1:0];
                default:                   r_bitmap_mode <= pwdata[0];
            endcase
        end
    end

    hbrd_decode u_decode (
        .i_req         (r_in),
        .i_backup_kind (r_backup_kind),
        .i_bitmap_mode (r_bitmap_mode),
        .o_rsp         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_req.valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_req.valid) begin
            r_in <= n_in;
        end
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.target         = r_out.target;
    assign o_rsp.offset         = r_out.offset;
    assign o_rsp.wait_cycles    = r_out.wait_cycles;
    assign o_rsp.drop           = r_out.drop;
    assign o_rsp.store_width    = r_out.store_width;
    assign o_rsp.store_data     = r_out.store_data;
    assign o_rsp.fixed_read     = r_out.fixed_read;
    assign o_rsp.fixed_value    = r_out.fixed_value;
    assign o_rsp.replicate_byte = r_out.replicate_byte;

endmodule

### rtl/hbrd_decode.sv
module hbrd_decode (
    input  hbrd_pkg::t_req i_req,
    input  logic [1:0]     i_backup_kind,
    input  logic           i_bitmap_mode,
    output hbrd_pkg::t_rsp o_rsp
);

    logic        wr;
    logic [1:0]  sz;
    logic [27:0] a;
    logic [3:0]  rgn;
    logic [27:0] al;
    logic [31:0] wmask;
    logic [31:0] dup;
    logic [16:0] v;
    logic [16:0] vf;
    logic        vram_quirk;
    logic        vram_bg;
    logic [1:0]  bsel;
    logic [7:0]  bbyte;

    always_comb begin
        wr  = i_req.func;
        sz  = (i_req.access_size == hbrd_pkg::SZ_RSVD) ? hbrd_pkg::SZ_WORD : i_req.access_size;
        a   = i_req.address[27:0];
        rgn = a[27:24];

        case (sz)
            hbrd_pkg::SZ_BYTE: begin
                al    = a;
                wmask = 32'h0000_00FF;
                bsel  = 2'd0;
            end
            hbrd_pkg::SZ_HALF: begin
                al    = {a[27:1], 1'b0};
                wmask = 32'h0000_FFFF;
                bsel  = {1'b0, a[0]};
            end
            default: begin
                al    = {a[27:2], 2'b00};
                wmask = 32'hFFFF_FFFF;
                bsel  = a[1:0];
            end
        endcase

        dup = {16'h0000, i_req.write_data[7:0], i_req.write_data[7:0]};

        case (bsel)
            2'd0:    bbyte = i_req.write_data[7:0];
            2'd1:    bbyte = i_req.write_data[15:8];
            2'd2:    bbyte = i_req.write_data[23:16];
            default: bbyte = i_req.write_data[31:24];
        endcase

        // upper 32K of VRAM mirrors the 32K below it
        v          = al[16:0];
        vram_quirk = i_bitmap_mode && (v[16:14] == 3'b110);
        vf         = (v[16:15] == 2'b11) ? {v[16], 1'b0, v[14:0]} : v;
        vram_bg    = i_bitmap_mode ? (vf <= hbrd_pkg::VRAM_BG_END_BITMAP) : !vf[16];

        o_rsp.target         = hbrd_pkg::TGT_NONE;
        o_rsp.offset         = '0;
        o_rsp.wait_cycles    = (sz == hbrd_pkg::SZ_WORD) ? hbrd_pkg::WAIT_WORD[rgn]
                                                         : hbrd_pkg::WAIT_NARROW[rgn];
        o_rsp.drop           = 1'b0;
        o_rsp.store_width    = sz;
        o_rsp.store_data     = wr ? (i_req.write_data & wmask) : 32'h0;
        o_rsp.fixed_read     = 1'b0;
        o_rsp.fixed_value    = 32'h0;
        o_rsp.replicate_byte = 1'b0;

        case (rgn)
            hbrd_pkg::RGN_BIOS: begin
                o_rsp.target = hbrd_pkg::TGT_BIOS;
                o_rsp.offset = {11'b0, al[13:0]};
                o_rsp.drop   = wr;
            end
            hbrd_pkg::RGN_UNMAP: begin
                o_rsp.drop       = wr;
                o_rsp.fixed_read = !wr;
            end
            hbrd_pkg::RGN_EWRAM: begin
                o_rsp.target = hbrd_pkg::TGT_EWRAM;
                o_rsp.offset = {7'b0, al[17:0]};
            end
            hbrd_pkg::RGN_IWRAM: begin
                o_rsp.target = hbrd_pkg::TGT_IWRAM;
                o_rsp.offset = {10'b0, al[14:0]};
            end
            hbrd_pkg::RGN_IO: begin
                o_rsp.target = hbrd_pkg::TGT_IO;
                o_rsp.offset = {15'b0, al[9:0]};
            end
            hbrd_pkg::RGN_PALETTE: begin
                o_rsp.target = hbrd_pkg::TGT_PALETTE;
                o_rsp.offset = {15'b0, al[9:0]};
                if (wr && sz == hbrd_pkg::SZ_BYTE) begin
                    o_rsp.offset      = {15'b0, a[9:1], 1'b0};
                    o_rsp.store_width = hbrd_pkg::SZ_HALF;
                    o_rsp.store_data  = dup;
                end
            end
            hbrd_pkg::RGN_VRAM: begin
                o_rsp.target = hbrd_pkg::TGT_VRAM;
                if (vram_quirk) begin
                    // bitmap overflow area: reads zero, writes lost
                    o_rsp.drop       = wr;
                    o_rsp.fixed_read = !wr;
                end else begin
                    o_rsp.offset = {8'b0, vf};
                    if (wr && sz == hbrd_pkg::SZ_BYTE) begin
                        if (vram_bg) begin
                            o_rsp.offset      = {8'b0, vf[16:1], 1'b0};
                            o_rsp.store_width = hbrd_pkg::SZ_HALF;
                            o_rsp.store_data  = dup;
                        end else begin
                            o_rsp.drop = 1'b1;
                        end
                    end
                end
            end
            hbrd_pkg::RGN_OAM: begin
                o_rsp.target = hbrd_pkg::TGT_OAM;
                o_rsp.offset = {15'b0, al[9:0]};
                o_rsp.drop   = wr && (sz == hbrd_pkg::SZ_BYTE);
            end
            hbrd_pkg::RGN_ROM_D: begin
                o_rsp.offset = al[24:0];
                if (i_backup_kind == hbrd_pkg::BK_EEPROM) begin
                    o_rsp.target = hbrd_pkg::TGT_EEPROM;
                end else begin
                    o_rsp.target = hbrd_pkg::TGT_ROM;
                    o_rsp.drop   = wr;
                end
            end
            hbrd_pkg::RGN_SAVE_E, hbrd_pkg::RGN_SAVE_F: begin
                if (i_backup_kind == hbrd_pkg::BK_SRAM || i_backup_kind == hbrd_pkg::BK_FLASH) begin
                    o_rsp.target = hbrd_pkg::TGT_BACKUP;
                    o_rsp.offset = {9'b0, a[15:0]};
                    if (wr) begin
                        o_rsp.store_width = hbrd_pkg::SZ_BYTE;
                        o_rsp.store_data  = {24'h0, bbyte};
                    end else begin
                        o_rsp.replicate_byte = (sz != hbrd_pkg::SZ_BYTE);
                    end
                end else begin
                    // open bus on the save area: all ones
                    o_rsp.drop        = wr;
                    o_rsp.fixed_read  = !wr;
                    o_rsp.fixed_value = wr ? 32'h0 : wmask;
                end
            end
            default: begin
                o_rsp.target = hbrd_pkg::TGT_ROM;
                o_rsp.offset = al[24:0];
                o_rsp.drop   = wr;
            end
        endcase

        if (o_rsp.drop) begin
            o_rsp.store_data = 32'h0;
        end
    end

endmodule

### rtl/hbrd_chk.sv
module hbrd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_wait_cycles,
    input logic        i_drop,
    input logic [31:0] i_store_data,
    input logic        i_fixed_read,
    input logic [31:0] i_fixed_value,
    input logic        i_replicate_byte,
    input logic [24:0] i_offset
);

    // a stalled response beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_offset)
            && $stable(i_store_data) && $stable(i_wait_cycles))
        else $error("response changed while stalled");

    // a dropped write never carries data, a fixed answer is never a backup read, and no beat is both dropped and fixed
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_drop && i_store_data != 32'h0)
            && !(i_fixed_read && i_replicate_byte)
            && !(i_drop && i_fixed_read))
        else $error("inconsistent drop / fixed flags");

    a_fixed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_fixed_read |-> i_fixed_value == 32'h0)
        else $error("fixed value without fixed read");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_wait_cycles != 4'd0 && i_wait_cycles <= 4'd8)
        else $error("wait states out of range");

    // the pipeline only fills to two beats, so an idle output means ready input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request stalled with empty response stage");

endmodule

bind handheld_bus_region_decoder hbrd_chk u_hbrd_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_wait_cycles    (o_rsp.wait_cycles),
    .i_drop           (o_rsp.drop),
    .i_store_data     (o_rsp.store_data),
    .i_fixed_read     (o_rsp.fixed_read),
    .i_fixed_value    (o_rsp.fixed_value),
    .i_replicate_byte (o_rsp.replicate_byte),
    .i_offset         (o_rsp.offset)
);

### tb/sv/handheld_bus_region_decoder_tb.sv
`timescale 1ns / 1ps

module handheld_bus_region_decoder_tb;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam int RANDOM_PER_PHASE = 228;
    localparam int LONG_HOLD_CYCLES = 90;

    localparam logic [1:0] PHASE_KIND [8] = '{
        hbrd_pkg::BK_NONE, hbrd_pkg::BK_SRAM, hbrd_pkg::BK_FLASH, hbrd_pkg::BK_EEPROM,
        hbrd_pkg::BK_EEPROM, hbrd_pkg::BK_FLASH, hbrd_pkg::BK_SRAM, hbrd_pkg::BK_NONE
    };
    localparam logic PHASE_BITMAP [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    class decode_scoreboard;
        logic [1:0]     backup_kind;
        logic           bitmap_mode;
        hbrd_pkg::t_rsp expected_decodes[$];
        hbrd_pkg::t_req outstanding_accesses[$];
        int             errors;

        function new();
            backup_kind = hbrd_pkg::BK_NONE;
            bitmap_mode = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        static function logic [3:0] wait_states(logic [1:0] sz, logic [3:0] rgn);
            if (sz == hbrd_pkg::SZ_WORD) begin
                case (rgn)
                    hbrd_pkg::RGN_EWRAM:                          return 4'd6;
                    hbrd_pkg::RGN_PALETTE, hbrd_pkg::RGN_VRAM:    return 4'd2;
                    hbrd_pkg::RGN_SAVE_E:                         return 4'd8;
                    hbrd_pkg::RGN_BIOS, hbrd_pkg::RGN_UNMAP, hbrd_pkg::RGN_IWRAM,
                    hbrd_pkg::RGN_IO, hbrd_pkg::RGN_OAM,
                    hbrd_pkg::RGN_SAVE_F:                         return 4'd1;
                    default:                                      return 4'd4;
                endcase
            end
            case (rgn)
                hbrd_pkg::RGN_EWRAM:                              return 4'd3;
                hbrd_pkg::RGN_SAVE_E:                             return 4'd5;
                hbrd_pkg::RGN_BIOS, hbrd_pkg::RGN_UNMAP, hbrd_pkg::RGN_IWRAM,
                hbrd_pkg::RGN_IO, hbrd_pkg::RGN_PALETTE, hbrd_pkg::RGN_VRAM,
                hbrd_pkg::RGN_OAM, hbrd_pkg::RGN_SAVE_F:          return 4'd1;
                default:                                          return 4'd2;
            endcase
        endfunction

        function hbrd_pkg::t_rsp decode_access(hbrd_pkg::t_req acc);
            logic [1:0]     sz;
            logic [27:0]    a;
            logic [27:0]    al;
            logic [3:0]     rgn;
            logic [31:0]    wmask;
            logic [31:0]    dup;
            logic [16:0]    v;
            logic [16:0]    bg_end;
            logic [4:0]     sh;
            hbrd_pkg::t_rsp r;
            sz    = (acc.access_size == hbrd_pkg::SZ_RSVD) ? hbrd_pkg::SZ_WORD
                                                           : acc.access_size;
            a     = acc.address[27:0];   // top nibble mirrors
            rgn   = a[27:24];
            al    = (sz == hbrd_pkg::SZ_BYTE) ? a :
                    (sz == hbrd_pkg::SZ_HALF) ? {a[27:1], 1'b0} : {a[27:2], 2'b00};
            wmask = (sz == hbrd_pkg::SZ_BYTE) ? 32'h0000_00FF :
                    (sz == hbrd_pkg::SZ_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            dup   = {16'h0, acc.write_data[7:0], acc.write_data[7:0]};
            r     = '0;
            r.target      = hbrd_pkg::TGT_NONE;
            r.wait_cycles = wait_states(sz, rgn);
            r.store_width = sz;
            r.store_data  = (acc.func == ACC_WRITE) ? (acc.write_data & wmask) : 32'h0;
            case (rgn)
                hbrd_pkg::RGN_BIOS: begin
                    r.target = hbrd_pkg::TGT_BIOS;
                    r.offset = {11'b0, al[13:0]};
                    r.drop   = acc.func;
                end
                hbrd_pkg::RGN_UNMAP: begin
                    r.drop       = acc.func;
                    r.fixed_read = !acc.func;
                end
                hbrd_pkg::RGN_EWRAM: begin
                    r.target = hbrd_pkg::TGT_EWRAM;
                    r.offset = {7'b0, al[17:0]};
                end
                hbrd_pkg::RGN_IWRAM: begin
                    r.target = hbrd_pkg::TGT_IWRAM;
                    r.offset = {10'b0, al[14:0]};
                end
                hbrd_pkg::RGN_IO: begin
                    r.target = hbrd_pkg::TGT_IO;
                    r.offset = {15'b0, al[9:0]};
                end
                hbrd_pkg::RGN_PALETTE: begin
                    r.target = hbrd_pkg::TGT_PALETTE;
                    r.offset = {15'b0, al[9:0]};
                    if (acc.func == ACC_WRITE && sz == hbrd_pkg::SZ_BYTE) begin
                        r.offset      = {15'b0, a[9:1], 1'b0};
                        r.store_width = hbrd_pkg::SZ_HALF;
                        r.store_data  = dup;
                    end
                end
                hbrd_pkg::RGN_VRAM: begin
                    r.target = hbrd_pkg::TGT_VRAM;
                    v        = al[16:0];
                    bg_end   = bitmap_mode ? 17'h13FFF : 17'h0FFFF;
                    if (bitmap_mode && v[16:14] == 3'b110) begin
                        // bitmap overflow window: offset forced to zero
                        r.drop       = acc.func;
                        r.fixed_read = !acc.func;
                    end else begin
                        if (v > 17'h17FFF) v = v - 17'h08000;
                        r.offset = {8'b0, v};
                        if (acc.func == ACC_WRITE && sz == hbrd_pkg::SZ_BYTE) begin
                            if (v <= bg_end) begin
                                r.offset      = {8'b0, v[16:1], 1'b0};
                                r.store_width = hbrd_pkg::SZ_HALF;
                                r.store_data  = dup;
                            end else begin
                                r.drop = 1'b1;
                            end
                        end
                    end
                end
                hbrd_pkg::RGN_OAM: begin
                    r.target = hbrd_pkg::TGT_OAM;
                    r.offset = {15'b0, al[9:0]};
                    r.drop   = (acc.func == ACC_WRITE) && (sz == hbrd_pkg::SZ_BYTE);
                end
                hbrd_pkg::RGN_ROM_D: begin
                    r.offset = al[24:0];
                    if (backup_kind == hbrd_pkg::BK_EEPROM) begin
                        r.target = hbrd_pkg::TGT_EEPROM;
                    end else begin
                        r.target = hbrd_pkg::TGT_ROM;
                        r.drop   = acc.func;
                    end
                end
                hbrd_pkg::RGN_SAVE_E, hbrd_pkg::RGN_SAVE_F: begin
                    if (backup_kind == hbrd_pkg::BK_SRAM || backup_kind == hbrd_pkg::BK_FLASH)
                    begin
                        r.target = hbrd_pkg::TGT_BACKUP;
                        r.offset = {9'b0, a[15:0]};
                        if (acc.func == ACC_WRITE) begin
                            sh = (sz == hbrd_pkg::SZ_BYTE) ? 5'd0 :
                                 (sz == hbrd_pkg::SZ_HALF) ? {1'b0, a[0], 3'b000}
                                                           : {a[1:0], 3'b000};
                            r.store_width = hbrd_pkg::SZ_BYTE;
                            r.store_data  = (acc.write_data >> sh) & 32'h0000_00FF;
                        end else begin
                            r.replicate_byte = (sz != hbrd_pkg::SZ_BYTE);
                        end
                    end else begin
                        // no save chip: open bus reads as all ones
                        r.drop        = acc.func;
                        r.fixed_read  = !acc.func;
                        r.fixed_value = (acc.func == ACC_WRITE) ? 32'h0 : wmask;
                    end
                end
                default: begin
                    r.target = hbrd_pkg::TGT_ROM;
                    r.offset = al[24:0];
                    r.drop   = acc.func;
                end
            endcase
            if (r.drop) r.store_data = '0;
            return r;
        endfunction

        function void note_access(hbrd_pkg::t_req acc);
            expected_decodes.push_back(decode_access(acc));
            outstanding_accesses.push_back(acc);
        endfunction

        task field_check(string name, logic [31:0] exp_v, logic [31:0] got_v,
                         hbrd_pkg::t_req acc);
            if (got_v !== exp_v)
                report($sformatf("%s expected %h got %h (func %0d size %0d addr %h data %h)",
                                 name, exp_v, got_v, acc.func, acc.access_size,
                                 acc.address, acc.write_data));
        endtask

        task check_decode(hbrd_pkg::t_rsp got);
            hbrd_pkg::t_rsp exp_r;
            hbrd_pkg::t_req acc;
            if (expected_decodes.size() == 0) begin
                report("response beat with no access outstanding");
                return;
            end
            exp_r = expected_decodes.pop_front();
            acc   = outstanding_accesses.pop_front();
            field_check("target",         exp_r.target,         got.target,         acc);
            field_check("offset",         exp_r.offset,         got.offset,         acc);
            field_check("wait_cycles",    exp_r.wait_cycles,    got.wait_cycles,    acc);
            field_check("drop",           exp_r.drop,           got.drop,           acc);
            field_check("store_width",    exp_r.store_width,    got.store_width,    acc);
            field_check("store_data",     exp_r.store_data,     got.store_data,     acc);
            field_check("fixed_read",     exp_r.fixed_read,     got.fixed_read,     acc);
            field_check("fixed_value",    exp_r.fixed_value,    got.fixed_value,    acc);
            field_check("replicate_byte", exp_r.replicate_byte, got.replicate_byte, acc);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hbrd_req_if req_if();
    hbrd_rsp_if rsp_if();

    decode_scoreboard sb;
    hbrd_pkg::t_rsp   seen_rsp;
    logic             long_hold_request;
    int               rx_cycle;
    int               rx_mode;
    int               hold_left;

    handheld_bus_region_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver: switches between four stall modes, plus one long hold-off on request
    initial begin
        rsp_if.ready      = 1'b0;
        long_hold_request = 1'b0;
        rx_cycle          = 0;
        rx_mode           = 0;
        hold_left         = 0;
    end

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (long_hold_request) begin
            hold_left         = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
                2:       rsp_if.ready <= (rx_cycle % 3 != 0);
                default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen_rsp.target         = hbrd_pkg::t_target'(rsp_if.target);
            seen_rsp.offset         = rsp_if.offset;
            seen_rsp.wait_cycles    = rsp_if.wait_cycles;
            seen_rsp.drop           = rsp_if.drop;
            seen_rsp.store_width    = rsp_if.store_width;
            seen_rsp.store_data     = rsp_if.store_data;
            seen_rsp.fixed_read     = rsp_if.fixed_read;
            seen_rsp.fixed_value    = rsp_if.fixed_value;
            seen_rsp.replicate_byte = rsp_if.replicate_byte;
            sb.check_decode(seen_rsp);
        end
    end

    function automatic hbrd_pkg::t_req make_access(logic func, logic [1:0] sz,
                                                   logic [31:0] addr, logic [31:0] data);
        hbrd_pkg::t_req acc;
        acc.func        = func;
        acc.access_size = sz;
        acc.address     = addr;
        acc.write_data  = data;
        return acc;
    endfunction

    function automatic hbrd_pkg::t_req random_access();
        hbrd_pkg::t_req acc;
        logic [16:0]    corner;
        int             pick;
        acc.func        = 1'($urandom_range(0, 1));
        acc.access_size = 2'($urandom_range(0, 3));
        acc.address     = $urandom;
        acc.write_data  = $urandom;
        pick            = $urandom_range(0, 9);
        if (pick < 3) begin
            // VRAM around the mirror, bitmap end and overflow window edges
            case ($urandom_range(0, 4))
                0:       corner = 17'h00000;
                1:       corner = 17'h10000;
                2:       corner = 17'h14000;
                3:       corner = 17'h18000;
                default: corner = 17'h1C000;
            endcase
            acc.address[27:24] = hbrd_pkg::RGN_VRAM;
            acc.address[16:0]  = corner + 17'($urandom_range(0, 7)) - 17'd4;
        end else if (pick < 5) begin
            acc.address[27:24] = $urandom_range(0, 1) ? hbrd_pkg::RGN_SAVE_E
                                                      : hbrd_pkg::RGN_SAVE_F;
        end
        return acc;
    endfunction

    task automatic offer(hbrd_pkg::t_req acc);
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.func        <= acc.func;
        req_if.access_size <= acc.access_size;
        req_if.address     <= acc.address;
        req_if.write_data  <= acc.write_data;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_access(acc);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int k = 0; k < burst && left > 0; k++) begin
                offer(random_access());
                left--;
            end
            pause_sender($urandom_range(0, 6));
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only touched once the pipe has drained
    task automatic set_config(logic [1:0] kind, logic bitmap);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        apb_write({hbrd_pkg::CFG_BACKUP_KIND, 2'b00}, {30'h0, kind});
        apb_write({hbrd_pkg::CFG_BITMAP_MODE, 2'b00}, {31'h0, bitmap});
        sb.backup_kind = kind;
        sb.bitmap_mode = bitmap;
    endtask

    task automatic directed_tile_mode();
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_BYTE, 32'h0000_0000, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_HALF, 32'hFFFF_FFFF, 32'h0000_0000));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_RSVD, 32'h0E00_0001, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0100_0000, 32'h1234_5678));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_WORD, 32'h1123_4567, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0500_03FF, 32'hDEAD_BEA5));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0600_FFFF, 32'h0000_003C));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0601_0000, 32'h0000_00C3));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0601_8001, 32'h0000_0077));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0700_0010, 32'h0000_0011));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_HALF, 32'h0700_0013, 32'hAAAA_5555));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_WORD, 32'h0800_0000, 32'hCAFE_F00D));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_WORD, 32'h0D00_0000, 32'h0000_0000));
    endtask

    task automatic directed_bitmap_mode();
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0601_3FFF, 32'h0000_00E1));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'h0601_4000, 32'h0000_001E));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_HALF, 32'h0601_8000, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_WORD, 32'h0601_BFFC, 32'h8765_4321));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_WORD, 32'h0601_C000, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_HALF, 32'h0E00_0003, 32'h1234_ABCD));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_WORD, 32'h0E00_0003, 32'h1234_ABCD));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_BYTE, 32'hFE00_FFFF, 32'hFFFF_FF80));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_WORD, 32'h0E00_FFFF, 32'h0000_0000));
        offer(make_access(ACC_READ,  hbrd_pkg::SZ_BYTE, 32'h0F00_0000, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_WORD, 32'h02FF_FFFF, 32'h0000_0000));
        offer(make_access(ACC_WRITE, hbrd_pkg::SZ_HALF, 32'h03FF_FFFF, 32'hFFFF_FFFF));
    endtask

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.func        = ACC_READ;
        req_if.access_size = hbrd_pkg::SZ_BYTE;
        req_if.address     = '0;
        req_if.write_data  = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sb                 = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 8; ph++) begin
            set_config(PHASE_KIND[ph], PHASE_BITMAP[ph]);
            if (ph == 0) directed_tile_mode();
            if (ph == 1) directed_bitmap_mode();
            // back-pressure: sink holds off while the source keeps offering
            if (ph == 2) long_hold_request = 1'b1;
            send_random(RANDOM_PER_PHASE);
            pause_sender(1);
        end

        for (int k = 0; k < 4000 && sb.pending() != 0; k++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/hbrd_pkg.sv
rtl/hbrd_if.sv
rtl/hbrd_decode.sv
rtl/handheld_bus_region_decoder.sv
rtl/hbrd_chk.sv
tb/sv/handheld_bus_region_decoder_tb.sv
